// File: rtl/core/iol_pkg.sv
// Shared types, codes and constants for the indexed ordered list unit.
`default_nettype none

package iol_pkg;

  // Fixed port field widths
  localparam int unsigned ModeWidth     = 3;
  localparam int unsigned PositionWidth = 5;
  localparam int unsigned ValueWidth    = 32;
  localparam int unsigned DataWidth     = 32;
  localparam int unsigned FoundWidth    = 4;
  localparam int unsigned StatusWidth   = 2;
  localparam int unsigned CountWidth    = 5;

  // Default storage configuration
  localparam int unsigned DefaultCapacity  = 16;
  localparam int unsigned DefaultDataWidth = 32;

  // Operation codes
  typedef enum logic [ModeWidth-1:0] {
    MODE_INSERT    = 3'd0,
    MODE_REMOVE    = 3'd1,
    MODE_READ      = 3'd2,
    MODE_OVERWRITE = 3'd3,
    MODE_FIND      = 3'd4,
    MODE_PRED      = 3'd5,
    MODE_SUCC      = 3'd6,
    MODE_CLEAR     = 3'd7
  } mode_e;

  // Result status codes
  typedef enum logic [StatusWidth-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Per-cell update control
  typedef struct packed {
    logic load_new;    // take the request value
    logic take_left;   // shift in from the lower position
    logic take_right;  // shift in from the higher position
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/iol_if.sv
// Request and result channel interfaces of the indexed ordered list unit.
`default_nettype none

interface iol_req_if
  import iol_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [ModeWidth-1:0]     mode;
  logic [PositionWidth-1:0] position;
  logic [ValueWidth-1:0]    value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface iol_rsp_if
  import iol_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [DataWidth-1:0]   data;
  logic [FoundWidth-1:0]  found_position;
  logic [StatusWidth-1:0] status;
  logic [CountWidth-1:0]  count;

  modport source (output valid, output data, output found_position, output status,
                  output count, input ready);
  modport sink   (input valid, input data, input found_position, input status,
                  input count, output ready);
endinterface

`default_nettype wire

// File: rtl/core/iol_cell.sv
// One storage cell of the list: holds a value, shifts with its neighbors, compares a key.
`default_nettype none

module iol_cell
  import iol_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DefaultDataWidth
) (
  input  wire logic                  clk_i,
  input  wire cell_ctl_t             ctl_i,
  input  wire logic [DATA_WIDTH-1:0] left_i,
  input  wire logic [DATA_WIDTH-1:0] right_i,
  input  wire logic [DATA_WIDTH-1:0] new_value_i,
  input  wire logic [DATA_WIDTH-1:0] key_i,
  output      logic [DATA_WIDTH-1:0] value_o,
  output      logic                  match_o
);

  logic [DATA_WIDTH-1:0] value_q, value_d;

  // Next value: new data, neighbor shift, or hold
  always_comb begin
    value_d = value_q;
    if (ctl_i.load_new) begin
      value_d = new_value_i;
    end else if (ctl_i.take_left) begin
      value_d = left_i;
    end else if (ctl_i.take_right) begin
      value_d = right_i;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign match_o = (value_q == key_i);

endmodule

`default_nettype wire

// File: rtl/core/indexed_ordered_list_unit.sv
// Top level of the indexed ordered list unit: control, cell chain and result register.
// An accepted request's result is in the output register in the next cycle.
// Throughput: 1 request per cycle while no result is stalled; every cell shifts or compares in the same cycle.
// A request is taken while a finished result waits, as long as the result is taken too.
// Reset (rst_ni low, asynchronous) empties the list and drops any pending result;
// cell contents are not cleared and are never read before being written.
`default_nettype none

module indexed_ordered_list_unit
  import iol_pkg::*;
#(
  parameter int unsigned CAPACITY   = DefaultCapacity,
  parameter int unsigned DATA_WIDTH = DefaultDataWidth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  iol_req_if.sink   in_i,
  iol_rsp_if.source out_o
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned IW   = $clog2(CAPACITY);
  localparam int unsigned PW   = (CW > PositionWidth) ? CW : PositionWidth;
  localparam int unsigned FW   = (IW > FoundWidth) ? IW : FoundWidth;
  localparam int unsigned OCW  = (CW > CountWidth) ? CW : CountWidth;
  localparam int unsigned VW   = (DATA_WIDTH > ValueWidth) ? DATA_WIDTH : ValueWidth;
  localparam int unsigned ODW  = (DATA_WIDTH > DataWidth) ? DATA_WIDTH : DataWidth;

  // Control and result registers
  logic [CW-1:0]          count_q, count_d;
  logic                   out_valid_q;
  logic [DataWidth-1:0]   data_q, data_d;
  logic [FoundWidth-1:0]  found_q, found_d;
  status_e                status_q, status_d;
  logic [CountWidth-1:0]  out_count_q;

  logic fire;
  mode_e mode;

  // Cell chain signals
  cell_ctl_t             ctl [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]   match;
  logic [DATA_WIDTH-1:0] key;
  logic [VW-1:0]         value_ext;

  logic [PW:0]           pos_ext;
  logic [PW:0]           cnt_ext;
  logic [PW:0]           rd_addr;
  logic [IW-1:0]         rd_idx;
  logic [DATA_WIDTH-1:0] rd_val;
  logic [ODW-1:0]        rd_val_ext;
  logic                  any_match;
  logic [IW-1:0]         match_idx;
  logic [FW-1:0]         match_idx_ext;
  logic [OCW-1:0]        count_ext;
  logic                  op_ok;

  assign mode      = mode_e'(in_i.mode);
  assign fire      = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;

  assign value_ext = VW'(in_i.value);
  assign key       = value_ext[DATA_WIDTH-1:0];
  assign pos_ext   = (PW + 1)'(in_i.position);
  assign cnt_ext   = (PW + 1)'(count_q);

  // Single read port: target, predecessor or successor
  always_comb begin
    case (mode)
      MODE_PRED: rd_addr = pos_ext - 1'b1;
      MODE_SUCC: rd_addr = pos_ext + 1'b1;
      default:   rd_addr = pos_ext;
    endcase
  end
  assign rd_idx     = rd_addr[IW-1:0];
  assign rd_val     = cell_val[rd_idx];
  assign rd_val_ext = ODW'(rd_val);

  // First occupied cell that matches the key
  always_comb begin
    any_match = 1'b0;
    match_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i] && (i < int'(count_q))) begin
        any_match = 1'b1;
        match_idx = IW'(i);
      end
    end
  end
  assign match_idx_ext = FW'(match_idx);

  // Status, result fields and next count
  always_comb begin
    status_d = ST_OK;
    count_d  = count_q;
    op_ok    = 1'b0;
    data_d   = '0;
    found_d  = '0;
    unique case (mode)
      MODE_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_d = ST_RANGE;
        end else if (cnt_ext >= (PW + 1)'(CAPACITY)) begin
          status_d = ST_FULL;
        end else begin
          op_ok   = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          status_d = ST_RANGE;
        end else begin
          op_ok   = 1'b1;
          data_d  = rd_val_ext[DataWidth-1:0];
          count_d = count_q - 1'b1;
        end
      end
      MODE_READ: begin
        if (pos_ext >= cnt_ext) begin
          status_d = ST_RANGE;
        end else begin
          data_d = rd_val_ext[DataWidth-1:0];
        end
      end
      MODE_OVERWRITE: begin
        if (pos_ext >= cnt_ext) begin
          status_d = ST_RANGE;
        end else begin
          op_ok = 1'b1;
        end
      end
      MODE_FIND: begin
        if (any_match) begin
          found_d = match_idx_ext[FoundWidth-1:0];
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      MODE_PRED: begin
        if ((pos_ext >= cnt_ext) || (pos_ext == '0)) begin
          status_d = ST_RANGE;
        end else begin
          data_d = rd_val_ext[DataWidth-1:0];
        end
      end
      MODE_SUCC: begin
        if (rd_addr >= cnt_ext) begin
          status_d = ST_RANGE;
        end else begin
          data_d = rd_val_ext[DataWidth-1:0];
        end
      end
      MODE_CLEAR: begin
        count_d = '0;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Per-cell shift controls
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctl[i] = '0;
      if (fire && op_ok) begin
        case (mode)
          MODE_INSERT: begin
            ctl[i].load_new  = ((PW + 1)'(i) == pos_ext);
            ctl[i].take_left = ((PW + 1)'(i) > pos_ext);
          end
          MODE_REMOVE: begin
            ctl[i].take_right = ((PW + 1)'(i) >= pos_ext);
          end
          MODE_OVERWRITE: begin
            ctl[i].load_new = ((PW + 1)'(i) == pos_ext);
          end
          default: begin
            ctl[i] = '0;
          end
        endcase
      end
    end
  end

  // Cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_val;
    logic [DATA_WIDTH-1:0] right_val;

    if (g == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[g+1];
    end

    iol_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl[g]),
      .left_i      (left_val),
      .right_i     (right_val),
      .new_value_i (key),
      .key_i       (key),
      .value_o     (cell_val[g]),
      .match_o     (match[g])
    );
  end

  // Count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q <= count_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign count_ext = OCW'(count_d);

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      data_q      <= data_d;
      found_q     <= found_d;
      status_q    <= status_d;
      out_count_q <= count_ext[CountWidth-1:0];
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.data           = data_q;
  assign out_o.found_position = found_q;
  assign out_o.status         = status_q;
  assign out_o.count          = out_count_q;

endmodule

`default_nettype wire

// File: rtl/core/iol_checker.sv
// Port-level checker for the indexed ordered list unit, bound to the top level.
`default_nettype none

module iol_checker
  import iol_pkg::*;
#(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_i,
  input wire logic [ModeWidth-1:0]   in_mode_i,
  input wire logic                   out_valid_i,
  input wire logic                   out_ready_i,
  input wire logic [DataWidth-1:0]   out_data_i,
  input wire logic [StatusWidth-1:0] out_status_i,
  input wire logic [CountWidth-1:0]  out_count_i
);

  // Every accepted request shows a result on the next cycle
  a_req_gives_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> out_valid_i)
    else $error("accepted request produced no result");

  // A clear empties the list and always succeeds
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_mode_i == MODE_CLEAR)) |=>
      (out_count_i == '0) && (out_status_i == ST_OK))
    else $error("clear did not empty the list");

  // Full status only when the list holds CAPACITY values
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_status_i == ST_FULL)) |-> (out_count_i == CountWidth'(CAPACITY)))
    else $error("full status with list not full");

  // Failed operations return zero data
  a_err_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_status_i != ST_OK)) |-> (out_data_i == '0))
    else $error("nonzero data on failed operation");

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_data_i) && $stable(out_status_i) && $stable(out_count_i)))
    else $error("stalled result changed");

endmodule

bind indexed_ordered_list_unit iol_checker #(
  .CAPACITY (CAPACITY)
) u_iol_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_mode_i    (in_i.mode),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_data_i   (out_o.data),
  .out_status_i (out_o.status),
  .out_count_i  (out_o.count)
);

`default_nettype wire

// File: test/indexed_ordered_list_unit_tb.sv
// Self-checking testbench for the indexed ordered list unit: directed table, then random traffic.
module indexed_ordered_list_unit_tb;
  import iol_pkg::*;

  localparam int unsigned ListCap   = DefaultCapacity;
  localparam int          ClkPeriod = 12;
  localparam int unsigned RandItems = 850;
  localparam int unsigned PlanRows  = 28;

  // One result transaction as the list should report it
  typedef struct packed {
    logic [DataWidth-1:0]  data;
    logic [FoundWidth-1:0] found;
    status_e               status;
    logic [CountWidth-1:0] count;
  } list_rsp_t;

  // One row of the directed table; val steps by one on each repeat
  typedef struct {
    mode_e                    op;
    logic [PositionWidth-1:0] pos;
    logic [ValueWidth-1:0]    val;
    int unsigned              reps;
    bit                       typed;
    list_rsp_t                want;
  } stim_row_t;

  localparam list_rsp_t NoCheck = '0;

  logic clk;
  logic rst_n;

  iol_req_if req_ch ();
  iol_rsp_if rsp_ch ();

  indexed_ordered_list_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_ch),
    .out_o  (rsp_ch)
  );

  // Shadow copy of the list contents and length
  logic [DataWidth-1:0] list_cells [ListCap];
  int unsigned          list_len;

  list_rsp_t   expected_results [$];
  int unsigned mismatch_count;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  stim_row_t   plan [PlanRows];

  // Apply one request to the shadow list and return the result it should produce
  function automatic list_rsp_t apply_list_request(input mode_e op,
      input logic [PositionWidth-1:0] pos, input logic [ValueWidth-1:0] val);
    list_rsp_t   r;
    int unsigned p;
    int unsigned i;
    r = '0;
    r.status = ST_OK;
    p = pos;
    case (op)
      MODE_INSERT: begin
        if (p > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= ListCap) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i > p; i--) list_cells[i] = list_cells[i-1];
          list_cells[p] = val;
          list_len++;
        end
      end
      MODE_REMOVE: begin
        if (p >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.data = list_cells[p];
          for (i = p; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      MODE_READ: begin
        if (p >= list_len) r.status = ST_RANGE;
        else r.data = list_cells[p];
      end
      MODE_OVERWRITE: begin
        if (p >= list_len) r.status = ST_RANGE;
        else list_cells[p] = val;
      end
      MODE_FIND: begin
        r.status = ST_NOT_FOUND;
        for (i = 0; i < list_len; i++) begin
          if (list_cells[i] == val) begin
            r.found  = i[FoundWidth-1:0];
            r.status = ST_OK;
            break;
          end
        end
      end
      MODE_PRED: begin
        if (p >= list_len || p == 0) r.status = ST_RANGE;
        else r.data = list_cells[p-1];
      end
      MODE_SUCC: begin
        if (p + 1 >= list_len) r.status = ST_RANGE;
        else r.data = list_cells[p+1];
      end
      default: begin
        list_len = 0;
      end
    endcase
    r.count = list_len[CountWidth-1:0];
    return r;
  endfunction

  // Drive one request, wait for the handshake, then queue its expected result
  task automatic send_request(input mode_e op, input logic [PositionWidth-1:0] pos,
      input logic [ValueWidth-1:0] val, input bit typed, input list_rsp_t want);
    list_rsp_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.mode     <= op;
    req_ch.position <= pos;
    req_ch.value    <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = apply_list_request(op, pos, val);
    expected_results.insert(expected_results.size(), typed ? want : predicted);
  endtask

  // Random traffic; stretches favor growth or draining so both full and empty are hit
  task automatic send_random_burst(input int unsigned n);
    int unsigned              k;
    int unsigned              roll;
    int unsigned              ins_w;
    int unsigned              rem_w;
    mode_e                    op;
    logic [PositionWidth-1:0] pos;
    logic [ValueWidth-1:0]    val;
    for (k = 0; k < n; k++) begin
      if ((k / 80) % 2 == 0) begin
        ins_w = 45;
        rem_w = 10;
      end else begin
        ins_w = 15;
        rem_w = 40;
      end
      roll = $urandom_range(99);
      if (roll < ins_w) op = MODE_INSERT;
      else if (roll < ins_w + rem_w) op = MODE_REMOVE;
      else if (roll == 99) op = MODE_CLEAR;
      else op = mode_e'($urandom_range(int'(MODE_SUCC), int'(MODE_READ)));

      // mostly in-range positions, some anywhere in the field
      if ($urandom_range(99) < 15) pos = PositionWidth'($urandom_range(31));
      else if (op == MODE_INSERT) pos = PositionWidth'($urandom_range(list_len));
      else if (list_len > 0) pos = PositionWidth'($urandom_range(list_len - 1));
      else pos = '0;

      // small values and stored values make find hits and duplicates likely
      roll = $urandom_range(99);
      if (roll < 30) val = ValueWidth'($urandom_range(7));
      else if (roll < 45 && list_len > 0) val = list_cells[$urandom_range(list_len - 1)];
      else if (roll < 50) val = '1;
      else val = $urandom;

      send_request(op, pos, val, 1'b0, NoCheck);
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Result side: random stalls, compare each accepted transaction with the oldest expectation
  initial begin
    list_rsp_t got;
    list_rsp_t want;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.data   = rsp_ch.data;
        got.found  = rsp_ch.found_position;
        got.status = status_e'(rsp_ch.status);
        got.count  = rsp_ch.count;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] unexpected result: data=%h found=%0d status=%0d count=%0d",
                     $realtime, got.data, got.found, got.status, got.count);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got.data !== want.data || got.found !== want.found ||
              got.status !== want.status || got.count !== want.count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"[%0t] mismatch: expected data=%h found=%0d status=%0d count=%0d,",
                        " got data=%h found=%0d status=%0d count=%0d"},
                       $realtime, want.data, want.found, want.status, want.count,
                       got.data, got.found, got.status, got.count);
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Stimulus
  initial begin
    int unsigned r;
    int unsigned k;
    int unsigned ph;
    // op, pos, val, repeats, typed, expected {data, found, status, count}
    plan = '{
      '{MODE_READ,      5'd0,  32'h0,         1,  1'b1, '{32'h0, 4'd0, ST_RANGE, 5'd0}},
      '{MODE_REMOVE,    5'd0,  32'h0,         1,  1'b1, '{32'h0, 4'd0, ST_RANGE, 5'd0}},
      '{MODE_FIND,      5'd0,  32'h0,         1,  1'b1, '{32'h0, 4'd0, ST_NOT_FOUND, 5'd0}},
      '{MODE_PRED,      5'd0,  32'h0,         1,  1'b1, '{32'h0, 4'd0, ST_RANGE, 5'd0}},
      '{MODE_SUCC,      5'd0,  32'h0,         1,  1'b1, '{32'h0, 4'd0, ST_RANGE, 5'd0}},
      '{MODE_INSERT,    5'd1,  32'h5,         1,  1'b1, '{32'h0, 4'd0, ST_RANGE, 5'd0}},
      '{MODE_INSERT,    5'd0,  32'hFFFF_FFFF, 1,  1'b1, '{32'h0, 4'd0, ST_OK, 5'd1}},
      '{MODE_INSERT,    5'd1,  32'h0,         1,  1'b1, '{32'h0, 4'd0, ST_OK, 5'd2}},
      '{MODE_READ,      5'd0,  32'h0,         1,  1'b1, '{32'hFFFF_FFFF, 4'd0, ST_OK, 5'd2}},
      '{MODE_READ,      5'd1,  32'h0,         1,  1'b0, NoCheck},
      '{MODE_OVERWRITE, 5'd2,  32'h1,         1,  1'b1, '{32'h0, 4'd0, ST_RANGE, 5'd2}},
      '{MODE_OVERWRITE, 5'd0,  32'hAAAA_AAAA, 1,  1'b0, NoCheck},
      '{MODE_PRED,      5'd1,  32'h0,         1,  1'b0, NoCheck},
      '{MODE_SUCC,      5'd0,  32'h0,         1,  1'b0, NoCheck},
      '{MODE_SUCC,      5'd1,  32'h0,         1,  1'b1, '{32'h0, 4'd0, ST_RANGE, 5'd2}},
      '{MODE_FIND,      5'd0,  32'h0,         1,  1'b0, NoCheck},
      '{MODE_INSERT,    5'd31, 32'h7,         1,  1'b1, '{32'h0, 4'd0, ST_RANGE, 5'd2}},
      '{MODE_READ,      5'd31, 32'h0,         1,  1'b1, '{32'h0, 4'd0, ST_RANGE, 5'd2}},
      '{MODE_REMOVE,    5'd0,  32'h0,         1,  1'b0, NoCheck},
      // fill to capacity from the front
      '{MODE_INSERT,    5'd0,  32'h5555_5550, 15, 1'b0, NoCheck},
      '{MODE_INSERT,    5'd16, 32'h0,         1,  1'b1, '{32'h0, 4'd0, ST_FULL, 5'd16}},
      '{MODE_INSERT,    5'd17, 32'h0,         1,  1'b1, '{32'h0, 4'd0, ST_RANGE, 5'd16}},
      '{MODE_FIND,      5'd0,  32'h0,         1,  1'b0, NoCheck},
      '{MODE_SUCC,      5'd15, 32'h0,         1,  1'b1, '{32'h0, 4'd0, ST_RANGE, 5'd16}},
      '{MODE_PRED,      5'd15, 32'h0,         1,  1'b0, NoCheck},
      '{MODE_REMOVE,    5'd15, 32'h0,         1,  1'b0, NoCheck},
      '{MODE_CLEAR,     5'd0,  32'h0,         1,  1'b1, '{32'h0, 4'd0, ST_OK, 5'd0}},
      '{MODE_READ,      5'd0,  32'h0,         1,  1'b1, '{32'h0, 4'd0, ST_RANGE, 5'd0}}
    };
    rst_n           = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.mode     = MODE_INSERT;
    req_ch.position = '0;
    req_ch.value    = '0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    list_len        = 0;
    mismatch_count  = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, no idling on either side
    for (r = 0; r < PlanRows; r++)
      for (k = 0; k < plan[r].reps; k++)
        send_request(plan[r].op, plan[r].pos, plan[r].val + k, plan[r].typed, plan[r].want);

    // Random phases with different idle mixes; drain fully between phases
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  <= 0;
          snk_stall_pct <= 0;
        end
        1: begin
          src_idle_pct  <= 63;
          snk_stall_pct <= 0;
        end
        2: begin
          src_idle_pct  <= 0;
          snk_stall_pct <= 63;
        end
        default: begin
          src_idle_pct  <= 17;
          snk_stall_pct <= 17;
        end
      endcase
      send_random_burst(RandItems / 4);
      req_ch.valid <= 1'b0;
      @(posedge clk);
      while (expected_results.size() != 0) @(posedge clk);
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(ClkPeriod * 400000);
    $display("FAILURE");
    $finish;
  end

endmodule
